// ----- rtl/core/rgbc_pkg.sv -----
`default_nettype none

package rgbc_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;
   localparam int POS_W       = 10;
   localparam int CHAN_W      = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_KERNEL_SELECT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT  = 2'd2;

   localparam int FRAME_WIDTH_RST  = 640;
   localparam int FRAME_HEIGHT_RST = 480;
   localparam int FRAME_MIN        = 3;

   typedef enum logic [1:0] {
      KERNEL_BLUR     = 2'd0,
      KERNEL_SHARPEN  = 2'd1,
      KERNEL_EMBOSS   = 2'd2,
      KERNEL_IDENTITY = 2'd3
   } kernel_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   // indexed [row][col]
   typedef pixel_type [2:0][2:0] window_type;

endpackage

`default_nettype wire

// ----- rtl/core/rgbc_kernel.sv -----
`default_nettype none

module rgbc_kernel (
   input  rgbc_pkg::kernel_type kernel_select,
   input  rgbc_pkg::window_type win,
   output rgbc_pkg::pixel_type  pix
);

   logic [rgbc_pkg::CHAN_W-1:0] px [3][3];
   logic signed [11:0]          sum;
   logic [23:0]                 word;
   logic [23:0]                 res;

   function automatic logic signed [11:0] ext(input logic [rgbc_pkg::CHAN_W-1:0] v);
      ext = $signed({4'b0000, v});
   endfunction

   always_comb begin
      res  = '0;
      sum  = '0;
      word = '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            px[i][j] = '0;
         end
      end
      for (int ch = 0; ch < 3; ch++) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               word     = win[i][j];
               px[i][j] = word[(2-ch)*8 +: 8];
            end
         end
         unique case (kernel_select)
            rgbc_pkg::KERNEL_BLUR: begin
               sum = ext(px[0][0] >> 4) + ext(px[0][1] >> 3) + ext(px[0][2] >> 4)
                   + ext(px[1][0] >> 3) + ext(px[1][1] >> 2) + ext(px[1][2] >> 3)
                   + ext(px[2][0] >> 4) + ext(px[2][1] >> 3) + ext(px[2][2] >> 4);
            end
            rgbc_pkg::KERNEL_SHARPEN: begin
               sum = ext(px[1][1]) * 12'sd5 - ext(px[0][1]) - ext(px[1][0])
                   - ext(px[1][2]) - ext(px[2][1]);
            end
            rgbc_pkg::KERNEL_EMBOSS: begin
               sum = ext(px[1][1]) + ext(px[1][2]) + ext(px[2][1])
                   + ext(px[2][2]) * 12'sd2 - ext(px[0][0]) * 12'sd2
                   - ext(px[0][1]) - ext(px[1][0]);
            end
            rgbc_pkg::KERNEL_IDENTITY: begin
               sum = ext(px[1][1]);
            end
            default: begin
               sum = ext(px[1][1]);
            end
         endcase
         // clamp to 0..255
         if (sum < 12'sd0) begin
            res[(2-ch)*8 +: 8] = 8'd0;
         end else if (sum > 12'sd255) begin
            res[(2-ch)*8 +: 8] = 8'd255;
         end else begin
            res[(2-ch)*8 +: 8] = sum[7:0];
         end
      end
   end

   assign pix = rgbc_pkg::pixel_type'(res);

endmodule

`default_nettype wire

// ----- rtl/core/rgb_conv3x3_stream.sv -----
// rgb_conv3x3_stream: 3x3 convolution over an RGB pixel stream in raster order.
// req_* carries one pixel per transaction (req_valid / req_stall), with
// req_start_of_frame marking the first pixel of a frame (row 0, column 0).
// rsp_* carries one filtered interior pixel per transaction with its row,
// column and last_of_frame; border pixels give no result, and pixels past
// frame_height rows are dropped until the next start of frame.
// csr_* writes kernel_select (0), frame_width (1), frame_height (2); csr_ready
// is always high. Sizes are clamped to 3..MAX_WIDTH / 3..MAX_HEIGHT.
// Throughput: one pixel per cycle while the output is not stalled. Each pixel
// reads both line stores once and writes them back once, on separate ports,
// so the read/write pair per pixel sets the rate. A window's result passes
// the store read, the window stage and the kernel and clamp register.
// When rsp_stall is high the output register holds its result; the internal
// stages keep filling until full, then req_stall rises.
// Reset clears the pipeline, the position counters and the registers to their
// defaults (blur, 640 x 480); the line stores are not cleared and the first
// two rows of a frame rewrite them before they are used.
`default_nettype none

module rgb_conv3x3_stream #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     req_valid,
   output logic                                    req_stall,
   input  wire  [7:0]                              req_red,
   input  wire  [7:0]                              req_green,
   input  wire  [7:0]                              req_blue,
   input  wire                                     req_start_of_frame,
   output logic                                    rsp_valid,
   input  wire                                     rsp_stall,
   output logic [7:0]                              rsp_out_red,
   output logic [7:0]                              rsp_out_green,
   output logic [7:0]                              rsp_out_blue,
   output logic [9:0]                              rsp_out_row,
   output logic [9:0]                              rsp_out_col,
   output logic                                    rsp_last_of_frame,
   input  wire                                     csr_valid,
   output logic                                    csr_ready,
   input  wire  [rgbc_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  wire  [rgbc_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 1);
   localparam int WIDTH_RST  = (rgbc_pkg::FRAME_WIDTH_RST > MAX_WIDTH) ?
                               MAX_WIDTH : rgbc_pkg::FRAME_WIDTH_RST;
   localparam int HEIGHT_RST = (rgbc_pkg::FRAME_HEIGHT_RST > MAX_HEIGHT) ?
                               MAX_HEIGHT : rgbc_pkg::FRAME_HEIGHT_RST;

   // configuration
   rgbc_pkg::kernel_type kernel_ff;
   logic [WW-1:0]        width_ff;
   logic [RW-1:0]        height_ff;

   // position counters
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   // line stores
   rgbc_pkg::pixel_type upper_mem  [MAX_WIDTH];
   rgbc_pkg::pixel_type middle_mem [MAX_WIDTH];
   rgbc_pkg::pixel_type up_rd_ff;
   rgbc_pkg::pixel_type mid_rd_ff;

   // window columns: [0..2] column c-2, [3..5] column c-1
   rgbc_pkg::pixel_type win_ff [6];

   // stage 1: store read outstanding
   logic                s1_v_ff;
   logic                s1_int_ff;
   logic                s1_last_ff;
   logic [CW-1:0]       s1_idx_ff;
   rgbc_pkg::pixel_type s1_pix_ff;
   logic [9:0]          s1_row_ff;
   logic [9:0]          s1_col_ff;

   // stage 2: full window
   logic                 s2_v_ff;
   logic                 s2_last_ff;
   rgbc_pkg::window_type s2_win_ff;
   logic [9:0]           s2_row_ff;
   logic [9:0]           s2_col_ff;

   // output register
   logic                rsp_valid_ff;
   rgbc_pkg::pixel_type rsp_pix_ff;
   logic [9:0]          rsp_row_ff;
   logic [9:0]          rsp_col_ff;
   logic                rsp_last_ff;

   rgbc_pkg::pixel_type filt_pix;
   rgbc_pkg::pixel_type req_pix;

   logic          req_accept;
   logic          take;
   logic          ignore;
   logic          interior;
   logic          wrap;
   logic          last;
   logic [CW-1:0] cur_col;
   logic [RW-1:0] cur_row;
   logic [WW-1:0] cur_col_w;
   logic          out_en;
   logic          s2_take;
   logic          s1_go;

   assign req_pix = '{red: req_red, green: req_green, blue: req_blue};

   // position of the incoming pixel
   always_comb begin
      cur_col   = req_start_of_frame ? '0 : col_ff;
      cur_row   = req_start_of_frame ? '0 : row_ff;
      cur_col_w = WW'(cur_col);
      ignore    = (cur_row >= height_ff);
      interior  = (cur_row >= RW'(2)) && (cur_col_w >= WW'(2)) && (cur_col_w < width_ff);
      wrap      = ((cur_col_w + WW'(1)) >= width_ff);
      last      = (cur_row == height_ff - RW'(1)) && (cur_col_w == width_ff - WW'(1));
   end

   // handshake between stages
   assign out_en     = !rsp_valid_ff || !rsp_stall;
   assign s2_take    = !s2_v_ff || out_en;
   assign s1_go      = s1_v_ff && (!s1_int_ff || s2_take);
   assign req_stall  = s1_v_ff && !s1_go;
   assign req_accept = req_valid && !req_stall;
   assign take       = req_accept && !ignore;
   assign csr_ready  = 1'b1;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (take) begin
         if (wrap) begin
            col_in = '0;
            row_in = cur_row + RW'(1);
         end else begin
            col_in = cur_col + CW'(1);
            row_in = cur_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff <= rgbc_pkg::KERNEL_BLUR;
         width_ff  <= WW'(WIDTH_RST);
         height_ff <= RW'(HEIGHT_RST);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rgbc_pkg::CSR_KERNEL_SELECT: begin
               kernel_ff <= rgbc_pkg::kernel_type'(csr_wdata[1:0]);
            end
            rgbc_pkg::CSR_FRAME_WIDTH: begin
               if (32'(csr_wdata) < rgbc_pkg::FRAME_MIN) begin
                  width_ff <= WW'(rgbc_pkg::FRAME_MIN);
               end else if (32'(csr_wdata) > MAX_WIDTH) begin
                  width_ff <= WW'(MAX_WIDTH);
               end else begin
                  width_ff <= WW'(csr_wdata);
               end
            end
            rgbc_pkg::CSR_FRAME_HEIGHT: begin
               if (32'(csr_wdata) < rgbc_pkg::FRAME_MIN) begin
                  height_ff <= RW'(rgbc_pkg::FRAME_MIN);
               end else if (32'(csr_wdata) > MAX_HEIGHT) begin
                  height_ff <= RW'(MAX_HEIGHT);
               end else begin
                  height_ff <= RW'(csr_wdata);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (take) begin
            s1_v_ff <= 1'b1;
         end else if (s1_go) begin
            s1_v_ff <= 1'b0;
         end
         if (s1_go && s1_int_ff) begin
            s2_v_ff <= 1'b1;
         end else if (out_en) begin
            s2_v_ff <= 1'b0;
         end
         if (out_en) begin
            rsp_valid_ff <= s2_v_ff;
         end
      end
   end

   // line store read when an in-frame pixel is accepted, write back when stage 1 moves on
   always_ff @(posedge clock) begin
      if (take) begin
         up_rd_ff  <= upper_mem[cur_col];
         mid_rd_ff <= middle_mem[cur_col];
      end
      if (s1_go) begin
         upper_mem[s1_idx_ff]  <= mid_rd_ff;
         middle_mem[s1_idx_ff] <= s1_pix_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (take) begin
         s1_int_ff  <= interior;
         s1_last_ff <= last;
         s1_idx_ff  <= cur_col;
         s1_pix_ff  <= req_pix;
         s1_row_ff  <= 10'(cur_row - RW'(1));
         s1_col_ff  <= 10'(cur_col - CW'(1));
      end
      if (s1_go) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= up_rd_ff;
         win_ff[4] <= mid_rd_ff;
         win_ff[5] <= s1_pix_ff;
      end
      if (s1_go && s1_int_ff) begin
         s2_win_ff[0][0] <= win_ff[0];
         s2_win_ff[1][0] <= win_ff[1];
         s2_win_ff[2][0] <= win_ff[2];
         s2_win_ff[0][1] <= win_ff[3];
         s2_win_ff[1][1] <= win_ff[4];
         s2_win_ff[2][1] <= win_ff[5];
         s2_win_ff[0][2] <= up_rd_ff;
         s2_win_ff[1][2] <= mid_rd_ff;
         s2_win_ff[2][2] <= s1_pix_ff;
         s2_row_ff       <= s1_row_ff;
         s2_col_ff       <= s1_col_ff;
         s2_last_ff      <= s1_last_ff;
      end
      if (out_en && s2_v_ff) begin
         rsp_pix_ff  <= filt_pix;
         rsp_row_ff  <= s2_row_ff;
         rsp_col_ff  <= s2_col_ff;
         rsp_last_ff <= s2_last_ff;
      end
   end

   rgbc_kernel u_kernel (
      .kernel_select (kernel_ff),
      .win           (s2_win_ff),
      .pix           (filt_pix)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_red       = rsp_pix_ff.red;
   assign rsp_out_green     = rsp_pix_ff.green;
   assign rsp_out_blue      = rsp_pix_ff.blue;
   assign rsp_out_row       = rsp_row_ff;
   assign rsp_out_col       = rsp_col_ff;
   assign rsp_last_of_frame = rsp_last_ff;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

   localparam int MAX_DIM        = 1024;
   localparam int RANDOM_PIXELS  = 250;
   localparam int WIDE_PIXELS    = 40;
   localparam int TALL_ROWS      = 50;
   localparam int SETTLE_CYCLES  = 8;
   localparam int END_CYCLES     = 20;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DIRECTED_ROWS  = 27;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [9:0] row;
      logic [9:0] col;
      logic       last_of_frame;
   } result_type;

   typedef struct packed {
      logic                             is_write;
      logic [rgbc_pkg::CSR_INDEX_W-1:0] index;
      logic [rgbc_pkg::CSR_DATA_W-1:0]  wdata;
      rgbc_pkg::pixel_type              px;
      logic                             sof;
      logic                             typed;
      result_type                       want;
   } plan_row_type;

   logic                             clock;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [7:0]                       req_red = '0;
   logic [7:0]                       req_green = '0;
   logic [7:0]                       req_blue = '0;
   logic                             req_start_of_frame = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [7:0]                       rsp_out_red;
   logic [7:0]                       rsp_out_green;
   logic [7:0]                       rsp_out_blue;
   logic [9:0]                       rsp_out_row;
   logic [9:0]                       rsp_out_col;
   logic                             rsp_last_of_frame;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [rgbc_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [rgbc_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // filter state mirror
   rgbc_pkg::pixel_type  upper_line [MAX_DIM];
   rgbc_pkg::pixel_type  middle_line [MAX_DIM];
   rgbc_pkg::pixel_type  window_cols [6];
   int                   col_cnt = 0;
   int                   row_cnt = 0;
   rgbc_pkg::kernel_type kernel_sel = rgbc_pkg::KERNEL_BLUR;
   int                   width_reg = rgbc_pkg::FRAME_WIDTH_RST;
   int                   height_reg = rgbc_pkg::FRAME_HEIGHT_RST;

   result_type   filtered_q [$];
   plan_row_type directed_plan [0:DIRECTED_ROWS-1];
   logic         no_idle = 1'b0;
   int           failures = 0;
   int           results_checked = 0;
   int           pixels_sent = 0;
   int           pixels_in_frame = 0;
   int           frames_run = 0;
   int           quiet_cycles = 0;

   rgb_conv3x3_stream u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_red            (req_red),
      .req_green          (req_green),
      .req_blue           (req_blue),
      .req_start_of_frame (req_start_of_frame),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_red        (rsp_out_red),
      .rsp_out_green      (rsp_out_green),
      .rsp_out_blue       (rsp_out_blue),
      .rsp_out_row        (rsp_out_row),
      .rsp_out_col        (rsp_out_col),
      .rsp_last_of_frame  (rsp_last_of_frame),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int clamp_size(int v);
      if (v < rgbc_pkg::FRAME_MIN) return rgbc_pkg::FRAME_MIN;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
   endfunction

   function automatic logic [7:0] apply_kernel(rgbc_pkg::kernel_type k,
                                               rgbc_pkg::window_type nb, int ch);
      int p [3][3];
      int s;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            p[i][j] = (ch == 0) ? int'(nb[i][j].red) :
                      (ch == 1) ? int'(nb[i][j].green) : int'(nb[i][j].blue);
      case (k)
         rgbc_pkg::KERNEL_BLUR: begin
            s = (p[0][0] >> 4) + (p[0][1] >> 3) + (p[0][2] >> 4)
              + (p[1][0] >> 3) + (p[1][1] >> 2) + (p[1][2] >> 3)
              + (p[2][0] >> 4) + (p[2][1] >> 3) + (p[2][2] >> 4);
         end
         rgbc_pkg::KERNEL_SHARPEN: begin
            s = 5 * p[1][1] - p[0][1] - p[1][0] - p[1][2] - p[2][1];
         end
         rgbc_pkg::KERNEL_EMBOSS: begin
            s = -2 * p[0][0] - p[0][1] - p[1][0] + p[1][1] + p[1][2] + p[2][1]
              + 2 * p[2][2];
         end
         default: begin
            s = p[1][1];
         end
      endcase
      if (s < 0) s = 0;
      if (s > 255) s = 255;
      return 8'(s);
   endfunction

   task automatic convolve_pixel(input rgbc_pkg::pixel_type px, input logic sof,
                                 output logic produced, output logic ignored,
                                 output result_type res);
      int                   w;
      int                   h;
      int                   r;
      int                   c;
      rgbc_pkg::pixel_type  up;
      rgbc_pkg::pixel_type  mid;
      rgbc_pkg::window_type nb;
      w = clamp_size(width_reg);
      h = clamp_size(height_reg);
      produced = 1'b0;
      ignored = 1'b0;
      res = '0;
      if (sof) begin
         row_cnt = 0;
         col_cnt = 0;
      end
      if (row_cnt >= h) begin
         ignored = 1'b1;
      end else begin
         r = row_cnt;
         c = col_cnt;
         up = upper_line[c % MAX_DIM];
         mid = middle_line[c % MAX_DIM];
         if (r >= 2 && c >= 2 && c < w) begin
            nb[0][0] = window_cols[0];
            nb[1][0] = window_cols[1];
            nb[2][0] = window_cols[2];
            nb[0][1] = window_cols[3];
            nb[1][1] = window_cols[4];
            nb[2][1] = window_cols[5];
            nb[0][2] = up;
            nb[1][2] = mid;
            nb[2][2] = px;
            res.red = apply_kernel(kernel_sel, nb, 0);
            res.green = apply_kernel(kernel_sel, nb, 1);
            res.blue = apply_kernel(kernel_sel, nb, 2);
            res.row = 10'(r - 1);
            res.col = 10'(c - 1);
            res.last_of_frame = (r == h - 1) && (c == w - 1);
            produced = 1'b1;
         end
         window_cols[0] = window_cols[3];
         window_cols[1] = window_cols[4];
         window_cols[2] = window_cols[5];
         window_cols[3] = up;
         window_cols[4] = mid;
         window_cols[5] = px;
         upper_line[c % MAX_DIM] = mid;
         middle_line[c % MAX_DIM] = px;
         if (c + 1 >= w) begin
            col_cnt = 0;
            row_cnt = r + 1;
         end else begin
            col_cnt = c + 1;
         end
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (filtered_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [rgbc_pkg::CSR_INDEX_W-1:0] index,
                            input logic [rgbc_pkg::CSR_DATA_W-1:0] wdata);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= wdata;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (index)
         rgbc_pkg::CSR_KERNEL_SELECT: kernel_sel = rgbc_pkg::kernel_type'(wdata[1:0]);
         rgbc_pkg::CSR_FRAME_WIDTH:   width_reg = int'(wdata);
         rgbc_pkg::CSR_FRAME_HEIGHT:  height_reg = int'(wdata);
         default: ;
      endcase
   endtask

   task automatic send_pixel(input rgbc_pkg::pixel_type px, input logic sof,
                             input logic typed, input result_type want);
      logic       produced;
      logic       ignored;
      result_type res;
      while (!no_idle && $urandom_range(0, 99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red <= px.red;
      req_green <= px.green;
      req_blue <= px.blue;
      req_start_of_frame <= sof;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      convolve_pixel(px, sof, produced, ignored, res);
      if (typed) filtered_q.push_back(want);
      else if (produced) filtered_q.push_back(res);
      pixels_sent++;
      if (!ignored) pixels_in_frame++;
   endtask

   function automatic rgbc_pkg::pixel_type random_pixel();
      rgbc_pkg::pixel_type p;
      p = rgbc_pkg::pixel_type'(24'($urandom));
      if ($urandom_range(0, 4) == 0) p.red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      if ($urandom_range(0, 4) == 0) p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      if ($urandom_range(0, 4) == 0) p.blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return p;
   endfunction

   // noisy frames may be cut short, run past their end or pause for a drain
   task automatic run_frame(input int w, input int h, input logic noisy);
      int total;
      int pause_at;
      int mode;
      int k;
      total = w * h;
      pause_at = -1;
      if (noisy) begin
         mode = $urandom_range(0, 9);
         if (mode == 0) total = $urandom_range(1, w * h - 1);
         else if (mode == 1) total = w * h + $urandom_range(1, 4);
         if ($urandom_range(0, 5) == 0) pause_at = $urandom_range(0, total - 1);
      end
      for (k = 0; k < total; k++) begin
         if (k == pause_at) wait_drained();
         send_pixel(random_pixel(), k == 0, 1'b0, '0);
      end
      frames_run++;
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         failures++;
      end
   endtask

   function automatic plan_row_type pixel_row(rgbc_pkg::pixel_type px, logic sof);
      plan_row_type e;
      e = '0;
      e.px = px;
      e.sof = sof;
      return e;
   endfunction

   function automatic plan_row_type csr_row(logic [rgbc_pkg::CSR_INDEX_W-1:0] index,
                                            int wdata);
      plan_row_type e;
      e = '0;
      e.is_write = 1'b1;
      e.index = index;
      e.wdata = rgbc_pkg::CSR_DATA_W'(wdata);
      return e;
   endfunction

   function automatic plan_row_type checked_row(rgbc_pkg::pixel_type px, result_type want);
      plan_row_type e;
      e = pixel_row(px, 1'b0);
      e.typed = 1'b1;
      e.want = want;
      return e;
   endfunction

   always @(posedge clock) begin : rsp_monitor
      result_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (filtered_q.size() == 0) begin
            $display("%0t: unexpected transaction, row %0d col %0d", $time, rsp_out_row,
                     rsp_out_col);
            failures++;
         end else begin
            want = filtered_q.pop_front();
            check_field("out_red", int'(want.red), int'(rsp_out_red));
            check_field("out_green", int'(want.green), int'(rsp_out_green));
            check_field("out_blue", int'(want.blue), int'(rsp_out_blue));
            check_field("out_row", int'(want.row), int'(rsp_out_row));
            check_field("out_col", int'(want.col), int'(rsp_out_col));
            check_field("last_of_frame", int'(want.last_of_frame),
                        int'(rsp_last_of_frame));
            results_checked++;
         end
      end
      rsp_stall <= !no_idle && ($urandom_range(0, 99) < 29);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("rgb_conv3x3_stream test failed");
         $finish;
      end
   end

   initial begin : stimulus
      int base;
      int wraw;
      int hraw;
      int nframes;
      int n;
      int f;

      // no start of frame yet, reset sizes
      directed_plan[0] = pixel_row(24'h000000, 1'b0);
      directed_plan[1] = pixel_row(24'hFFFFFF, 1'b0);
      // width below minimum, six rows
      directed_plan[2] = csr_row(rgbc_pkg::CSR_FRAME_WIDTH, 2);
      directed_plan[3] = csr_row(rgbc_pkg::CSR_FRAME_HEIGHT, 6);
      directed_plan[4] = csr_row(rgbc_pkg::CSR_KERNEL_SELECT, rgbc_pkg::KERNEL_IDENTITY);
      directed_plan[5] = pixel_row(24'h000000, 1'b1);
      directed_plan[6] = pixel_row(24'h000000, 1'b0);
      directed_plan[7] = pixel_row(24'h000000, 1'b0);
      directed_plan[8] = pixel_row(24'h000000, 1'b0);
      directed_plan[9] = pixel_row(24'hA55AC3, 1'b0);
      directed_plan[10] = pixel_row(24'h000000, 1'b0);
      directed_plan[11] = pixel_row(24'h000000, 1'b0);
      directed_plan[12] = pixel_row(24'hFF0000, 1'b0);
      directed_plan[13] = checked_row(24'h000000, '{8'hA5, 8'h5A, 8'hC3, 10'd1, 10'd1, 1'b0});
      // kernel changes between rows while nothing is pending
      directed_plan[14] = csr_row(rgbc_pkg::CSR_KERNEL_SELECT, rgbc_pkg::KERNEL_SHARPEN);
      directed_plan[15] = pixel_row(24'h102030, 1'b0);
      directed_plan[16] = pixel_row(24'h00FF00, 1'b0);
      directed_plan[17] = checked_row(24'h808080, '{8'hFF, 8'h00, 8'h00, 10'd2, 10'd1, 1'b0});
      directed_plan[18] = csr_row(rgbc_pkg::CSR_KERNEL_SELECT, rgbc_pkg::KERNEL_EMBOSS);
      directed_plan[19] = pixel_row(24'h123456, 1'b0);
      directed_plan[20] = pixel_row(24'hFFFFFF, 1'b0);
      directed_plan[21] = pixel_row(24'h0F0F0F, 1'b0);
      directed_plan[22] = csr_row(rgbc_pkg::CSR_KERNEL_SELECT, rgbc_pkg::KERNEL_BLUR);
      directed_plan[23] = pixel_row(24'hFFFFFF, 1'b0);
      directed_plan[24] = pixel_row(24'hFFFFFF, 1'b0);
      directed_plan[25] = pixel_row(24'hFFFFFF, 1'b0);
      // past the last row, dropped
      directed_plan[26] = pixel_row(24'h5A5A5A, 1'b0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (n = 0; n < DIRECTED_ROWS; n++) begin
         if (directed_plan[n].is_write)
            write_csr(directed_plan[n].index, directed_plan[n].wdata);
         else
            send_pixel(directed_plan[n].px, directed_plan[n].sof, directed_plan[n].typed,
                       directed_plan[n].want);
      end

      base = pixels_in_frame;
      while (pixels_in_frame - base < RANDOM_PIXELS) begin
         write_csr(rgbc_pkg::CSR_KERNEL_SELECT,
                   rgbc_pkg::CSR_DATA_W'($urandom_range(0, 3)));
         wraw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
         hraw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
         write_csr(rgbc_pkg::CSR_FRAME_WIDTH, rgbc_pkg::CSR_DATA_W'(wraw));
         write_csr(rgbc_pkg::CSR_FRAME_HEIGHT, rgbc_pkg::CSR_DATA_W'(hraw));
         nframes = $urandom_range(1, 3);
         for (f = 0; f < nframes; f++)
            run_frame(clamp_size(wraw), clamp_size(hraw), 1'b1);
      end

      // width above maximum, start of the first row only
      write_csr(rgbc_pkg::CSR_KERNEL_SELECT, rgbc_pkg::CSR_DATA_W'($urandom_range(0, 3)));
      write_csr(rgbc_pkg::CSR_FRAME_WIDTH, 11'd1500);
      write_csr(rgbc_pkg::CSR_FRAME_HEIGHT, 11'd3);
      for (n = 0; n < WIDE_PIXELS; n++)
         send_pixel(random_pixel(), n == 0, 1'b0, '0);
      frames_run++;

      // height above maximum, top rows back to back on both sides
      write_csr(rgbc_pkg::CSR_KERNEL_SELECT, rgbc_pkg::CSR_DATA_W'($urandom_range(0, 3)));
      write_csr(rgbc_pkg::CSR_FRAME_WIDTH, 11'd3);
      write_csr(rgbc_pkg::CSR_FRAME_HEIGHT, 11'd2047);
      no_idle = 1'b1;
      for (n = 0; n < 3 * TALL_ROWS; n++)
         send_pixel(random_pixel(), n == 0, 1'b0, '0);
      frames_run++;
      wait_drained();
      no_idle = 1'b0;

      req_valid <= 1'b0;
      while (filtered_q.size() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);

      $display("sent %0d pixels (%0d inside frames) in %0d frames, all four kernels,",
               pixels_sent, pixels_in_frame, frames_run);
      $display("clamped and oversized frames; %0d filtered pixels checked, %0d errors",
               results_checked, failures);
      if (failures == 0)
         $display("rgb_conv3x3_stream test passed");
      else
         $display("rgb_conv3x3_stream test failed");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/rgbc_pkg.sv
rtl/core/rgbc_kernel.sv
rtl/core/rgb_conv3x3_stream.sv
tb/testbench.sv
